// File: src/two_class_priority_admission_queue_assert.svh
// Assertion macros used by the admission queue controller.
`ifndef TWO_CLASS_PRIORITY_ADMISSION_QUEUE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_ADMISSION_QUEUE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define TCPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define TCPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/tcpq_pkg.sv
// Package with shared types and constants of the admission queue.
package tcpq_pkg;
  localparam int DEF_CAPACITY = 64;
  localparam logic [3:0] THRESH_RESET = 4'd7;

  typedef enum logic [1:0] {
    K_ADD = 2'd0, K_SERVE = 2'd1, K_SEARCH = 2'd2, K_NONE = 2'd3
  } kind_t;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_SERVED = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_FOUND = 3'd5;
  localparam logic [2:0] ST_NOTFOUND = 3'd6;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LATCH, OP_SCAN, OP_ADD, OP_HPUSH, OP_FPUSH, OP_HPOP, OP_FPOP,
    OP_FIND_SERVED, OP_REMOVE, OP_RES_SEARCH, OP_RES_EMPTY, OP_RES_NONE
  } op_t;

  typedef struct packed {
    logic scan_done;
    logic sift_done;
    logic match;
    logic free_found;
    logic full;
    logic heap_empty;
    logic fifo_empty;
    logic is_crit;
  } status_t;
endpackage

// File: src/tcpq_datapath.sv
// Datapath with entry table, heap, FIFO and sequential scan and sift units.
module tcpq_datapath import tcpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  logic [3:0]  threshold,
  input  logic [15:0] in_id,
  input  logic [7:0]  in_age,
  input  logic [3:0]  in_sev,
  output status_t     stat,
  output logic [2:0]  r_status,
  output logic [15:0] r_id,
  output logic [7:0]  r_age,
  output logic [3:0]  r_sev,
  output logic        r_crit
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [15:0] t_id [CAPACITY];
  logic [7:0]  t_age [CAPACITY];
  logic [3:0]  t_sev [CAPACITY];
  logic [CAPACITY-1:0] t_valid;
  logic [19:0] heap [CAPACITY];
  logic [15:0] fifo [CAPACITY];

  logic [CW-1:0] heap_count, fifo_count, scan_i;
  logic [AW-1:0] fifo_head, fifo_tail, hit_slot, free_slot;
  logic [15:0] key_id, t_rd_id, fifo_rd;
  logic [7:0] t_rd_age;
  logic [3:0] key_sev, t_rd_sev;
  logic t_rd_valid, hit, have_free, scanning, cmp_live;
  logic [AW-1:0] t_raddr, t_rd_slot;
  logic [CW-1:0] sift_i;
  logic sifting, sift_up, sift_ph, pop_load;
  logic [19:0] h_cur, hrd0, hrd1;
  logic [AW-1:0] h_ra0, h_ra1;

  assign stat.scan_done = !scanning;
  assign stat.sift_done = !sifting;
  assign stat.match = hit;
  assign stat.free_found = have_free;
  assign stat.full = (heap_count + fifo_count) >= CW'(CAPACITY);
  assign stat.heap_empty = heap_count == '0;
  assign stat.fifo_empty = fifo_count == '0;
  assign stat.is_crit = key_sev >= threshold;

  // Indices for heap sift.
  logic [CW:0] l_i, r_i, p_i;
  logic l_ok, r_ok, take_l, take_r;
  assign l_i = {sift_i, 1'b1};
  assign r_i = l_i + 1'b1;
  assign p_i = {1'b0, (sift_i - 1'b1) >> 1};
  assign l_ok = l_i < {1'b0, heap_count};
  assign r_ok = r_i < {1'b0, heap_count};
  assign take_l = l_ok && hrd0 > h_cur;
  assign take_r = r_ok && hrd1 > (take_l ? hrd0 : h_cur);

  logic [CW-1:0] scan_last;
  assign scan_last = CW'(CAPACITY - 1);

  assign h_ra0 = pop_load ? '0 : (sift_up ? p_i[AW-1:0] : l_i[AW-1:0]);
  assign h_ra1 = pop_load ? heap_count[AW-1:0] : r_i[AW-1:0];
  assign t_raddr = scanning ? scan_i[AW-1:0] : hit_slot;

  // The moving key is held in h_cur and written once its place is known.
  always_ff @(posedge clk) begin
    hrd0 <= heap[h_ra0];
    hrd1 <= heap[h_ra1];
    fifo_rd <= fifo[fifo_head];
    t_rd_id <= t_id[t_raddr];
    t_rd_age <= t_age[t_raddr];
    t_rd_sev <= t_sev[t_raddr];
    t_rd_valid <= t_valid[t_raddr];
    t_rd_slot <= t_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= '0;
      heap_count <= '0;
      fifo_count <= '0;
      fifo_head <= '0;
      fifo_tail <= '0;
      scanning <= 1'b0;
      sifting <= 1'b0;
      sift_up <= 1'b0;
      sift_ph <= 1'b0;
      pop_load <= 1'b0;
      cmp_live <= 1'b0;
    end else begin
      cmp_live <= (op == OP_SCAN) && scanning && (scan_i <= scan_last);
      case (op)
        OP_LATCH: begin
          key_id <= in_id;
          key_sev <= in_sev;
          h_cur <= {in_sev, in_id};
          r_age <= in_age;
          scanning <= 1'b1;
          scan_i <= '0;
          hit <= 1'b0;
          have_free <= 1'b0;
        end
        OP_FIND_SERVED: begin
          scanning <= 1'b1;
          scan_i <= '0;
          hit <= 1'b0;
        end
        OP_SCAN: begin
          if (scan_i <= scan_last) scan_i <= scan_i + 1'b1;
          if (cmp_live) begin
            if (t_rd_valid && t_rd_id == key_id && !hit) begin
              hit <= 1'b1;
              hit_slot <= t_rd_slot;
            end
            if (!t_rd_valid && !have_free) begin
              have_free <= 1'b1;
              free_slot <= t_rd_slot;
            end
            if (t_rd_slot == scan_last[AW-1:0]) scanning <= 1'b0;
          end
        end
        OP_ADD: begin
          t_valid[free_slot] <= 1'b1;
          t_id[free_slot] <= key_id;
          t_age[free_slot] <= r_age;
          t_sev[free_slot] <= key_sev;
          r_status <= ST_ADDED;
          r_id <= '0;
          r_age <= '0;
          r_sev <= '0;
          r_crit <= 1'b0;
          if (key_sev >= threshold) begin
            sift_i <= heap_count;
            heap_count <= heap_count + 1'b1;
            sifting <= 1'b1;
            sift_up <= 1'b1;
            sift_ph <= 1'b0;
            pop_load <= 1'b0;
          end else begin
            fifo[fifo_tail] <= key_id;
            fifo_tail <= (fifo_tail == AW'(CAPACITY - 1)) ? '0 : fifo_tail + 1'b1;
            fifo_count <= fifo_count + 1'b1;
          end
        end
        OP_HPOP: begin
          heap_count <= heap_count - 1'b1;
          sift_i <= '0;
          sifting <= 1'b1;
          sift_up <= 1'b0;
          sift_ph <= 1'b0;
          pop_load <= 1'b1;
          r_crit <= 1'b1;
        end
        OP_FPOP: begin
          key_id <= fifo_rd;
          fifo_head <= (fifo_head == AW'(CAPACITY - 1)) ? '0 : fifo_head + 1'b1;
          fifo_count <= fifo_count - 1'b1;
          r_crit <= 1'b0;
        end
        OP_HPUSH: begin
          if (!sift_ph) begin
            if (sift_up && sift_i == '0) begin
              heap[sift_i[AW-1:0]] <= h_cur;
              sifting <= 1'b0;
            end else sift_ph <= 1'b1;
          end else begin
            sift_ph <= 1'b0;
            if (pop_load) begin
              key_id <= hrd0[15:0];
              h_cur <= hrd1;
              pop_load <= 1'b0;
              if (heap_count == '0) sifting <= 1'b0;
            end else if (sift_up) begin
              if (hrd0 >= h_cur) begin
                heap[sift_i[AW-1:0]] <= h_cur;
                sifting <= 1'b0;
              end else begin
                heap[sift_i[AW-1:0]] <= hrd0;
                sift_i <= p_i[CW-1:0];
              end
            end else if (take_r) begin
              heap[sift_i[AW-1:0]] <= hrd1;
              sift_i <= r_i[CW-1:0];
            end else if (take_l) begin
              heap[sift_i[AW-1:0]] <= hrd0;
              sift_i <= l_i[CW-1:0];
            end else begin
              heap[sift_i[AW-1:0]] <= h_cur;
              sifting <= 1'b0;
            end
          end
        end
        OP_REMOVE: begin
          r_status <= ST_SERVED;
          r_id <= key_id;
          if (hit) begin
            r_age <= t_rd_age;
            r_sev <= t_rd_sev;
            t_valid[hit_slot] <= 1'b0;
          end else begin
            r_age <= '0;
            r_sev <= '0;
          end
        end
        OP_RES_SEARCH: begin
          r_crit <= 1'b0;
          if (hit) begin
            r_status <= ST_FOUND;
            r_id <= t_rd_id;
            r_age <= t_rd_age;
            r_sev <= t_rd_sev;
          end else begin
            r_status <= ST_NOTFOUND;
            r_id <= '0;
            r_age <= '0;
            r_sev <= '0;
          end
        end
        OP_RES_EMPTY, OP_RES_NONE, OP_FPUSH: begin
          r_status <= (op == OP_FPUSH) ? (hit ? ST_DUP : ST_FULL) : ST_EMPTY;
          r_id <= '0;
          r_age <= '0;
          r_sev <= '0;
          r_crit <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: src/tcpq_ctrl.sv
// Controller state machine sequencing one operation at a time.
module tcpq_ctrl import tcpq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  kind_t   in_kind,
  input  logic    out_busy,
  input  logic    out_fire,
  input  status_t stat,
  output op_t     op,
  output logic    in_rdy,
  output logic    res_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_ADD, S_SIFT, S_SERVE, S_SSCAN, S_REMOVE,
    S_RESULT, S_HOLD
  } state_t;
  state_t state;
  kind_t kind_q;

  always_comb begin
    op = OP_IDLE;
    case (state)
      S_IDLE: if (in_fire) op = (in_kind == K_SERVE) ?
          (!stat.heap_empty ? OP_HPOP : (!stat.fifo_empty ? OP_FPOP : OP_RES_EMPTY)) :
          (in_kind == K_NONE) ? OP_RES_NONE : OP_LATCH;
      S_SCAN, S_SSCAN: op = OP_SCAN;
      S_DECIDE: op = (kind_q == K_SEARCH) ? OP_RES_SEARCH :
          ((stat.match || !stat.free_found || stat.full) ? OP_FPUSH : OP_ADD);
      S_SIFT: op = stat.sift_done ? OP_IDLE : OP_HPUSH;
      S_SERVE: op = OP_FIND_SERVED;
      S_REMOVE: op = OP_REMOVE;
      default: op = OP_IDLE;
    endcase
  end

  assign in_rdy = (state == S_IDLE) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      kind_q <= K_ADD;
    end else begin
      if (out_fire) res_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_fire) begin
          kind_q <= in_kind;
          if (in_kind == K_SERVE)
            state <= (!stat.heap_empty) ? S_SIFT : (!stat.fifo_empty ? S_SERVE : S_HOLD);
          else if (in_kind == K_NONE) state <= S_HOLD;
          else state <= S_SCAN;
        end
        S_SCAN: if (stat.scan_done) state <= S_DECIDE;
        S_DECIDE: state <= (op == OP_ADD) ? S_SIFT : S_HOLD;
        S_SIFT: if (stat.sift_done) state <= (kind_q == K_SERVE) ? S_SERVE : S_HOLD;
        S_SERVE: state <= S_SSCAN;
        S_SSCAN: if (stat.scan_done) state <= S_REMOVE;
        S_REMOVE: state <= S_HOLD;
        S_HOLD: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "two_class_priority_admission_queue_assert.svh"
  `TCPQ_ASSERT_IMPL(a_no_accept_busy, in_fire, state == S_IDLE && !res_valid)
  `TCPQ_ASSERT_NEXT(a_hold_sets_valid, state == S_HOLD, res_valid)
  `TCPQ_ASSERT_IMPL(a_valid_idle, res_valid, state == S_IDLE)
endmodule

// File: src/two_class_priority_admission_queue.sv
// Top level of the two-class priority admission queue.
// The slave channel takes one word per operation: kind in tuser, and the
// id, age and severity in tdata. The master channel returns one word per
// operation with the status and the served or found fields.
// One operation is handled at a time. An add or search scans all CAPACITY
// table slots through a registered read, one per cycle. An add to the heap
// then sifts the new key up level by level.
// A serve from the heap loads the top and last keys, sifts down level by
// level, then scans the table. A serve from the FIFO also scans the table,
// and an empty serve or an unused kind goes straight to the result.
// The result stays in an output register until it is taken; while it waits
// no new word is accepted, so a stalled receiver stalls the sender, and the
// next word can be accepted in the cycle after the result is taken.
// The threshold register is written through cfg_we and cfg_data; the user must write it only while idle (not enforced).
// Reset clears all valid marks, the counts and the FIFO pointers and
// sets the threshold to seven.
module two_class_priority_admission_queue import tcpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // entry_id, entry_age, entry_severity, zero pad
  input  logic [1:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // status, out_id, out_age, out_severity, from_critical
);
  logic [3:0] threshold;
  op_t op;
  status_t stat;
  logic in_fire, out_fire;
  logic [2:0] r_status;
  logic [15:0] r_id;
  logic [7:0] r_age;
  logic [3:0] r_sev;
  logic r_crit;

  always_ff @(posedge clk) begin
    if (rst) threshold <= THRESH_RESET;
    else if (cfg_we) threshold <= cfg_data;
  end

  assign in_fire = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  tcpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_kind(kind_t'(s_tuser)),
    .out_busy(m_tvalid), .out_fire(out_fire), .stat(stat), .op(op),
    .in_rdy(s_tready), .res_valid(m_tvalid)
  );

  tcpq_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .op(op), .threshold(threshold),
    .in_id(s_tdata[15:0]), .in_age(s_tdata[23:16]), .in_sev(s_tdata[27:24]),
    .stat(stat), .r_status(r_status), .r_id(r_id), .r_age(r_age),
    .r_sev(r_sev), .r_crit(r_crit)
  );

  assign m_tdata = {r_crit, r_sev, r_age, r_id, r_status};
endmodule
